// File: src/iaq_pkg.sv
// ----------------------------------------------------------------------------
// iaq_pkg
// Shared types and constants for the int8 activation requantizer: activation
// mode codes, register indexes, saturation kinds and the pipeline depth.
// ----------------------------------------------------------------------------
package iaq_pkg;

    // Widths fixed by the data formats
    localparam int ACC_W   = 32;
    localparam int SCALE_W = 31;
    localparam int ZERO_W  = 8;
    localparam int OUT_W   = 8;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 31;

    // Q16 requantization shift
    localparam int QSHIFT  = 16;

    // Register stages from accepted word to result strobe
    localparam int PIPE_DEPTH = 4;

    // Output limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 8'sh7f;

    // Activation modes; codes 6 and 7 behave as none
    typedef enum logic [MODE_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_RELU    = 3'd1,
        ACT_RELU6   = 3'd2,
        ACT_SIGMOID = 3'd3,
        ACT_TANH    = 3'd4,
        ACT_LEAKY   = 3'd5
    } act_mode_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_SCALE = 2'd1,
        REG_ZERO  = 2'd2
    } reg_index_t;

    // How the final value is formed
    typedef enum logic [1:0] {
        SAT_NONE = 2'd0,
        SAT_LOW  = 2'd1,
        SAT_HIGH = 2'd2
    } sat_kind_t;

    // Breakpoint comparisons taken in the first stage
    typedef struct packed {
        logic neg;
        logic above_6s;
        logic below_m4s;
        logic above_4s;
        logic below_m2s;
        logic above_2s;
    } cmp_flags_t;

endpackage

// File: src/int8_activation_requantizer_unit.sv
// ----------------------------------------------------------------------------
// int8_activation_requantizer_unit
// Applies the configured activation to a signed 32-bit accumulator and
// requantizes it to int8 with a Q16 scale, zero point and clamp.
// ----------------------------------------------------------------------------
// done is the top valid bit and rises together with the registered out_value.
// Throughput: one word per cycle; busy is held low, the pipeline never stalls.
// Stages: breakpoint compare, activation select, 32x32 multiply, shift/clamp.
// Reset: valid bits clear, mode none, scale 1, zero point 0.
// The receiver cannot stall; every result is shown for exactly one cycle.
module int8_activation_requantizer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [iaq_pkg::ACC_W-1:0]    acc_value,
    output logic                                done,
    output logic signed [iaq_pkg::OUT_W-1:0]    out_value,
    input  logic                                wr_en,
    input  logic [iaq_pkg::IDX_W-1:0]           wr_index,
    input  logic [iaq_pkg::DATA_W-1:0]          wr_data
);

    localparam int WIDE_W = iaq_pkg::ACC_W + 3;
    localparam int PROD_W = iaq_pkg::ACC_W + iaq_pkg::SCALE_W;
    localparam int Q_W    = PROD_W - iaq_pkg::QSHIFT;
    localparam int SUM_W  = Q_W + 1;

    // Configuration registers
    logic [iaq_pkg::MODE_W-1:0]         mode_reg;
    logic [iaq_pkg::SCALE_W-1:0]        scale_reg;
    logic signed [iaq_pkg::ZERO_W-1:0]  zero_reg;

    // Pipeline registers
    logic [iaq_pkg::PIPE_DEPTH-1:0]     valid_reg;
    logic [iaq_pkg::PIPE_DEPTH-1:0]     valid_next;
    logic signed [iaq_pkg::ACC_W-1:0]   s1_x_reg;
    logic signed [iaq_pkg::ACC_W-1:0]   s1_div8_reg;
    logic signed [iaq_pkg::ACC_W-1:0]   s1_div2_reg;
    iaq_pkg::cmp_flags_t                s1_flags_reg;
    iaq_pkg::cmp_flags_t                s1_flags_next;
    logic signed [iaq_pkg::ACC_W-1:0]   s2_v_reg;
    logic signed [iaq_pkg::ACC_W-1:0]   s2_v_next;
    iaq_pkg::sat_kind_t                 s2_sat_reg;
    iaq_pkg::sat_kind_t                 s2_sat_next;
    logic signed [PROD_W-1:0]           s3_prod_reg;
    iaq_pkg::sat_kind_t                 s3_sat_reg;
    logic signed [iaq_pkg::OUT_W-1:0]   out_value_reg;
    logic signed [iaq_pkg::OUT_W-1:0]   out_value_next;

    // Stage 1 working signals
    logic signed [WIDE_W-1:0]           x_wide;
    logic signed [WIDE_W-1:0]           s2x_wide;
    logic signed [WIDE_W-1:0]           s4x_wide;
    logic signed [WIDE_W-1:0]           s6x_wide;
    logic signed [iaq_pkg::ACC_W-1:0]   div8_next;
    logic signed [iaq_pkg::ACC_W-1:0]   div2_next;

    // Stage 3 / 4 working signals
    logic signed [iaq_pkg::ACC_W-1:0]   scale_s;
    logic signed [2*iaq_pkg::ACC_W-1:0] prod_full;
    logic signed [SUM_W-1:0]            sum_wide;

    assign busy      = 1'b0;
    assign done      = valid_reg[iaq_pkg::PIPE_DEPTH-1];
    assign out_value = out_value_reg;

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= iaq_pkg::ACT_NONE;
            scale_reg <= iaq_pkg::SCALE_W'(1);
            zero_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                iaq_pkg::REG_MODE:  mode_reg  <= wr_data[iaq_pkg::MODE_W-1:0];
                iaq_pkg::REG_SCALE: scale_reg <= wr_data[iaq_pkg::SCALE_W-1:0];
                iaq_pkg::REG_ZERO:  zero_reg  <= wr_data[iaq_pkg::ZERO_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance valid bits one stage per cycle
    assign valid_next = {valid_reg[iaq_pkg::PIPE_DEPTH-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: breakpoints and truncating divisions
    always_comb
    begin
        x_wide   = {{3{acc_value[iaq_pkg::ACC_W-1]}}, acc_value};
        s2x_wide = {3'b0, scale_reg, 1'b0};
        s4x_wide = {2'b0, scale_reg, 2'b0};
        s6x_wide = s4x_wide + s2x_wide;

        s1_flags_next.neg       = acc_value[iaq_pkg::ACC_W-1];
        s1_flags_next.above_6s  = x_wide > s6x_wide;
        s1_flags_next.below_m4s = x_wide < -s4x_wide;
        s1_flags_next.above_4s  = x_wide > s4x_wide;
        s1_flags_next.below_m2s = x_wide < -s2x_wide;
        s1_flags_next.above_2s  = x_wide > s2x_wide;

        // Bias negatives so the arithmetic shift rounds toward zero
        div8_next = (acc_value + (acc_value[iaq_pkg::ACC_W-1] ? 32'sd7 : 32'sd0)) >>> 3;
        div2_next = (acc_value + (acc_value[iaq_pkg::ACC_W-1] ? 32'sd1 : 32'sd0)) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg     <= acc_value;
        s1_div8_reg  <= div8_next;
        s1_div2_reg  <= div2_next;
        s1_flags_reg <= s1_flags_next;
    end

    // Stage 2: pick the activated value or a saturation kind
    always_comb
    begin
        s2_v_next   = s1_x_reg;
        s2_sat_next = iaq_pkg::SAT_NONE;
        case (mode_reg)
            iaq_pkg::ACT_RELU:
            begin
                if (s1_flags_reg.neg)
                    s2_v_next = '0;
            end
            iaq_pkg::ACT_RELU6:
            begin
                // 6*scale is below the word here, so it fits 32 bits
                if (s1_flags_reg.neg)
                    s2_v_next = '0;
                else if (s1_flags_reg.above_6s)
                    s2_v_next = s6x_wide[iaq_pkg::ACC_W-1:0];
            end
            iaq_pkg::ACT_SIGMOID:
            begin
                s2_v_next = s1_div8_reg
                          + {2'b0, scale_reg[iaq_pkg::SCALE_W-1:1]};
                if (s1_flags_reg.below_m4s)
                    s2_sat_next = iaq_pkg::SAT_LOW;
                else if (s1_flags_reg.above_4s)
                    s2_sat_next = iaq_pkg::SAT_HIGH;
            end
            iaq_pkg::ACT_TANH:
            begin
                s2_v_next = s1_div2_reg;
                if (s1_flags_reg.below_m2s)
                    s2_sat_next = iaq_pkg::SAT_LOW;
                else if (s1_flags_reg.above_2s)
                    s2_sat_next = iaq_pkg::SAT_HIGH;
            end
            iaq_pkg::ACT_LEAKY:
            begin
                if (s1_flags_reg.neg)
                    s2_v_next = s1_div8_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_v_reg   <= s2_v_next;
        s2_sat_reg <= s2_sat_next;
    end

    // Stage 3: signed value times unsigned scale
    assign scale_s   = {1'b0, scale_reg};
    assign prod_full = s2_v_reg * scale_s;

    always_ff @(posedge clk)
    begin
        s3_prod_reg <= prod_full[PROD_W-1:0];
        s3_sat_reg  <= s2_sat_reg;
    end

    // Stage 4: floor shift, add zero point, clamp to int8
    always_comb
    begin
        sum_wide = {s3_prod_reg[PROD_W-1], s3_prod_reg[PROD_W-1:iaq_pkg::QSHIFT]}
                 + {{(SUM_W-iaq_pkg::ZERO_W){zero_reg[iaq_pkg::ZERO_W-1]}}, zero_reg};

        // In range when all bits above bit 7 match the sign
        if (sum_wide[SUM_W-1:iaq_pkg::OUT_W-1] == '0 ||
            sum_wide[SUM_W-1:iaq_pkg::OUT_W-1] == '1)
            out_value_next = sum_wide[iaq_pkg::OUT_W-1:0];
        else if (sum_wide[SUM_W-1])
            out_value_next = ~iaq_pkg::OUT_MAX;
        else
            out_value_next = iaq_pkg::OUT_MAX;

        case (s3_sat_reg)
            // -128 plus zero point, wrapped: flip the sign bit
            iaq_pkg::SAT_LOW:
                out_value_next = {~zero_reg[iaq_pkg::ZERO_W-1],
                                  zero_reg[iaq_pkg::ZERO_W-2:0]};
            iaq_pkg::SAT_HIGH:
                out_value_next = iaq_pkg::OUT_MAX;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

endmodule

// File: src/iaq_checker.sv
// ----------------------------------------------------------------------------
// iaq_checker
// Port-level checks on the requantizer: fixed latency, no lost or invented
// words, and no back-pressure on the command side.
// ----------------------------------------------------------------------------
module iaq_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // Hold busy low outside reset
    a_never_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        !busy
    ) else $error("busy raised; the unit must take a word every cycle");

    // Every accepted word gives its result after the pipeline depth
    a_word_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(iaq_pkg::PIPE_DEPTH) done
    ) else $error("accepted word gave no result at the expected cycle");

    // Every result traces back to an accepted word
    a_done_has_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, iaq_pkg::PIPE_DEPTH)
    ) else $error("result strobe with no accepted word behind it");

endmodule

bind int8_activation_requantizer_unit iaq_checker u_iaq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// File: tb/int8_activation_requantizer_unit_tb.sv
// ----------------------------------------------------------------------------
// int8_activation_requantizer_unit_tb
// Self-checking bench for the int8 activation requantizer. A queue-fed driver
// issues accumulator words under changing idle rates. A monitor compares each
// result strobe with the value predicted when the word was accepted. The bench
// steps through directed breakpoint cases and then random register settings.
// ----------------------------------------------------------------------------
module int8_activation_requantizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF        = 2;
    localparam int  RESET_CYCLES    = 7;
    localparam int  PHASES          = 24;
    localparam int  WORDS_PER_PHASE = 64;
    localparam int  IDLE_FIRST_PCT  = 29;
    localparam int  IDLE_SECOND_PCT = 48;
    localparam int  DRAIN_LIMIT     = 64;
    localparam int  REPORT_LIMIT    = 10;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    // Index past the last register; writes to it must be ignored
    localparam logic [iaq_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [iaq_pkg::OUT_W-1:0] OUT_MIN = -8'sd128;
    localparam longint ACC_LO = -64'sd2147483648;
    localparam longint ACC_HI = 64'sd2147483647;

    typedef struct {
        logic signed [iaq_pkg::ACC_W-1:0] acc;
        logic signed [iaq_pkg::OUT_W-1:0] out;
    } quant_expect_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             start     = 1'b0;
    logic                             busy;
    logic signed [iaq_pkg::ACC_W-1:0] acc_value = '0;
    logic                             done;
    logic signed [iaq_pkg::OUT_W-1:0] out_value;
    logic                             wr_en     = 1'b0;
    logic [iaq_pkg::IDX_W-1:0]        wr_index  = '0;
    logic [iaq_pkg::DATA_W-1:0]       wr_data   = '0;

    // Mirror of the configuration registers
    logic [iaq_pkg::MODE_W-1:0]        cfg_mode  = iaq_pkg::ACT_NONE;
    logic [iaq_pkg::SCALE_W-1:0]       cfg_scale = 31'd1;
    logic signed [iaq_pkg::ZERO_W-1:0] cfg_zero  = '0;

    logic signed [iaq_pkg::ACC_W-1:0] acc_pending_q[$];
    quant_expect_t                    quant_expect_q[$];
    quant_expect_t                    oldest;
    quant_expect_t                    accepted;
    int                               send_idle_pct = IDLE_FIRST_PCT;
    int                               error_count   = 0;

    int8_activation_requantizer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .acc_value (acc_value),
        .done      (done),
        .out_value (out_value),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Scale by Q16, floor the shift, add the zero point and clamp to int8
    function automatic logic signed [iaq_pkg::OUT_W-1:0] requantize(longint v);
        longint s;
        longint z;
        longint q;
        s = longint'(cfg_scale);
        z = longint'(cfg_zero);
        q = ((v * s) >>> iaq_pkg::QSHIFT) + z;
        if (q < -128)
            q = -128;
        if (q > 127)
            q = 127;
        return q[iaq_pkg::OUT_W-1:0];
    endfunction

    // Activation followed by requantization for the current settings
    function automatic logic signed [iaq_pkg::OUT_W-1:0] activate_quantize(
        logic signed [iaq_pkg::ACC_W-1:0] acc);
        longint x;
        longint s;
        logic signed [iaq_pkg::OUT_W-1:0] low_sat;
        x = longint'(acc);
        s = longint'(cfg_scale);
        // Low saturation wraps rather than clamps
        low_sat = cfg_zero + OUT_MIN;
        case (cfg_mode)
            iaq_pkg::ACT_RELU:
                return requantize(x > 0 ? x : 0);
            iaq_pkg::ACT_RELU6:
            begin
                if (x < 0)
                    return requantize(0);
                else if (x > 6 * s)
                    return requantize(6 * s);
                return requantize(x);
            end
            iaq_pkg::ACT_SIGMOID:
            begin
                if (x < -4 * s)
                    return low_sat;
                else if (x > 4 * s)
                    return iaq_pkg::OUT_MAX;
                return requantize(x / 8 + s / 2);
            end
            iaq_pkg::ACT_TANH:
            begin
                if (x < -2 * s)
                    return low_sat;
                else if (x > 2 * s)
                    return iaq_pkg::OUT_MAX;
                return requantize(x / 2);
            end
            iaq_pkg::ACT_LEAKY:
                return requantize(x > 0 ? x : x / 8);
            default:
                return requantize(x);
        endcase
    endfunction

    task automatic report_failure(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Write one register at a rising edge and track it in the mirror
    task automatic write_reg(logic [iaq_pkg::IDX_W-1:0] idx,
                             logic [iaq_pkg::DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            iaq_pkg::REG_MODE:  cfg_mode  = data[iaq_pkg::MODE_W-1:0];
            iaq_pkg::REG_SCALE: cfg_scale = data[iaq_pkg::SCALE_W-1:0];
            iaq_pkg::REG_ZERO:  cfg_zero  = data[iaq_pkg::ZERO_W-1:0];
            default:   ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Write all three registers; unused upper data bits carry noise
    task automatic apply_cfg(logic [iaq_pkg::MODE_W-1:0] mode,
                             logic [iaq_pkg::SCALE_W-1:0] scale,
                             logic [iaq_pkg::ZERO_W-1:0] zero);
        logic [iaq_pkg::DATA_W-1:0] d;
        d = iaq_pkg::DATA_W'($urandom);
        d[iaq_pkg::MODE_W-1:0] = mode;
        write_reg(iaq_pkg::REG_MODE, d);
        write_reg(iaq_pkg::REG_SCALE, scale);
        d = iaq_pkg::DATA_W'($urandom);
        d[iaq_pkg::ZERO_W-1:0] = zero;
        write_reg(iaq_pkg::REG_ZERO, d);
        @(negedge clk);
    endtask

    // Wait for every queued word to go in and every result to come back
    task automatic drain_pipeline();
        int waited;
        waited = 0;
        while (acc_pending_q.size() != 0)
            @(negedge clk);
        while (quant_expect_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (iaq_pkg::PIPE_DEPTH + 2) @(negedge clk);
    endtask

    // Driver: retire the accepted word, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            acc_value <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                accepted = '{acc: acc_value, out: activate_quantize(acc_value)};
                quant_expect_q = {quant_expect_q, accepted};
                void'(acc_pending_q.pop_front());
            end
            if (acc_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                start     <= 1'b1;
                acc_value <= acc_pending_q[0];
            end
            else
            begin
                start     <= 1'b0;
                acc_value <= $urandom;
            end
        end
    end

    // Monitor: match each result strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (quant_expect_q.size() == 0)
                report_failure($sformatf("unexpected result word %0d", out_value));
            else
            begin
                oldest = quant_expect_q.pop_front();
                if (out_value !== oldest.out)
                    report_failure($sformatf("out_value mismatch: acc %0d expected %0d got %0d",
                                             oldest.acc, oldest.out, out_value));
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [iaq_pkg::MODE_W-1:0]  mode;
        logic [iaq_pkg::SCALE_W-1:0] scale;
        logic [iaq_pkg::ZERO_W-1:0]  zero;
        int                          offset;
        longint                      s;
        longint                      t;
        longint                      span;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: identity mode, scale one, no zero point
        acc_pending_q = '{32'sh80000000, 32'sh7fffffff, 32'sh0};
        drain_pipeline();

        // Sigmoid breakpoints; low saturation with zero point -1 wraps to 127
        apply_cfg(iaq_pkg::ACT_SIGMOID, 31'd1000, -8'sd1);
        acc_pending_q = '{-32'sd4001, -32'sd4000, 32'sd4000, 32'sd4001};
        drain_pipeline();

        // Tanh breakpoints
        apply_cfg(iaq_pkg::ACT_TANH, 31'd1000, 8'sd5);
        acc_pending_q = '{-32'sd2001, -32'sd2000, 32'sd2000, 32'sd2001};
        drain_pipeline();

        // ReLU6 cap
        apply_cfg(iaq_pkg::ACT_RELU6, 31'd1000, 8'sd0);
        acc_pending_q = '{-32'sd1, 32'sd6000, 32'sd6001};
        drain_pipeline();

        // ReLU at the largest scale and zero point
        apply_cfg(iaq_pkg::ACT_RELU, 31'h7fffffff, 8'sd127);
        acc_pending_q = '{-32'sd5, 32'sd7};
        drain_pipeline();

        // Leaky ReLU rounding toward zero; an out-of-range write must not land
        apply_cfg(iaq_pkg::ACT_LEAKY, 31'd65536, -8'sd128);
        write_reg(REG_UNUSED, iaq_pkg::DATA_W'($urandom));
        @(negedge clk);
        acc_pending_q = '{-32'sd9, -32'sd8, -32'sd7, 32'sd3};
        drain_pipeline();

        // Unused mode codes, the first with zero scale
        apply_cfg(3'd7, 31'd0, 8'sd3);
        acc_pending_q = '{32'sh80000000, 32'sh7fffffff};
        drain_pipeline();
        apply_cfg(3'd6, 31'd65536, 8'sd0);
        acc_pending_q = '{-32'sd300};
        drain_pipeline();

        // Random settings, each with a batch of words, some aimed at its breakpoints
        offset = $urandom_range(7);
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = (p < PHASES / 3) ? IDLE_FIRST_PCT
                          : (p < 2 * PHASES / 3) ? IDLE_SECOND_PCT : 0;
            mode = iaq_pkg::MODE_W'((p + offset) % 8);
            case ($urandom_range(5))
                0: scale = ($urandom_range(2) == 0) ? 31'd0
                         : ($urandom_range(1) == 0) ? 31'd1 : 31'h7fffffff;
                1: scale = iaq_pkg::SCALE_W'(31'd65536 + $urandom_range(64) - 32);
                2: scale = iaq_pkg::SCALE_W'($urandom_range(1024, 1));
                3: scale = iaq_pkg::SCALE_W'($urandom_range(1 << 20, 1 << 16));
                default: scale = iaq_pkg::SCALE_W'($urandom);
            endcase
            if ($urandom_range(3) == 0)
                case ($urandom_range(3))
                    0: zero = 8'h80;
                    1: zero = 8'h7f;
                    2: zero = 8'h00;
                    default: zero = 8'hff;
                endcase
            else
                zero = iaq_pkg::ZERO_W'($urandom);
            apply_cfg(mode, scale, zero);

            s = longint'(cfg_scale);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                case ($urandom_range(3))
                    // Near a breakpoint of some mode, on either side
                    0:
                    begin
                        t = 2 * $urandom_range(3) * s;
                        if ($urandom_range(1) == 1)
                            t = -t;
                        t = t + longint'($urandom_range(6)) - 3;
                    end
                    // Across a span twice as wide as the one that maps onto the int8 range
                    1:
                    begin
                        span = (64'sd1 << 24) / (s + 1) + 1;
                        if (span > ACC_HI)
                            span = ACC_HI;
                        t = longint'($urandom) % (2 * span + 1) - span;
                    end
                    2:
                        t = longint'($urandom_range(2000)) - 1000;
                    default:
                        t = ACC_HI + 1;
                endcase
                if (t < ACC_LO || t > ACC_HI)
                    t = longint'($signed($urandom));
                acc_pending_q = {acc_pending_q, t[iaq_pkg::ACC_W-1:0]};
            end
            drain_pipeline();
        end

        if (quant_expect_q.size() != 0)
            report_failure($sformatf("%0d results never arrived", quant_expect_q.size()));
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
src/iaq_pkg.sv
src/int8_activation_requantizer_unit.sv
src/iaq_checker.sv
tb/int8_activation_requantizer_unit_tb.sv
